// File: sv/sawl_pkg.sv
// Shared types, codes and field layouts of the stop-and-wait ARQ link engine.
// No dependencies; every other file of the block refers to this package.
package sawl_pkg;

    // Default parameter values.
    localparam int DEF_ID_BITS     = 8;
    localparam int DEF_CACHE_DEPTH = 8;

    // Fixed field widths.
    localparam int ADDR_W   = 8;
    localparam int ID_W     = 8;
    localparam int FLAGS_W  = 8;
    localparam int CODE_W   = 2;
    localparam int ATTEMPT_W = 8;

    // Stream payload widths.
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    // Result payload bit positions.
    localparam int M_DEST_LSB   = 0;
    localparam int M_SRC_LSB    = 8;
    localparam int M_TYPE_LSB   = 16;
    localparam int M_ID_LSB     = 18;
    localparam int M_FLAGS_LSB  = 26;
    localparam int M_STATUS_LSB = 34;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 1'd1;
    localparam logic [ATTEMPT_W-1:0] MAX_RETRIES_RST = 8'd3;
    localparam logic [ATTEMPT_W-1:0] ATTEMPT_MAX     = 8'hFF;

    // Operation codes.
    localparam logic [CODE_W-1:0] OP_SEND    = 2'd0;
    localparam logic [CODE_W-1:0] OP_RX      = 2'd1;
    localparam logic [CODE_W-1:0] OP_TIMEOUT = 2'd2;

    // Receive status codes.
    localparam logic [CODE_W-1:0] RXS_OK  = 2'd0;
    localparam logic [CODE_W-1:0] RXS_CRC = 2'd1;

    // Frame types.
    localparam logic [CODE_W-1:0] TYPE_UNCONF = 2'd0;
    localparam logic [CODE_W-1:0] TYPE_CONF   = 2'd1;
    localparam logic [CODE_W-1:0] TYPE_ACK    = 2'd2;

    // Result actions.
    localparam logic [CODE_W-1:0] ACT_TRANSMIT = 2'd0;
    localparam logic [CODE_W-1:0] ACT_DELIVER  = 2'd1;
    localparam logic [CODE_W-1:0] ACT_FINISH   = 2'd2;
    localparam logic [CODE_W-1:0] ACT_BAD      = 2'd3;

    // Finish status codes.
    localparam logic [CODE_W-1:0] ST_OK      = 2'd0;
    localparam logic [CODE_W-1:0] ST_TIMEOUT = 2'd1;
    localparam logic [CODE_W-1:0] ST_RADIO   = 2'd2;

    // Controller to datapath commands.
    typedef struct packed {
        logic latch;
        logic search_clear;
        logic search_step;
        logic search_drain;
        logic load0;
        logic load1;
        logic commit;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic       need_search;
        logic       search_last;
        logic       out_free;
        logic [1:0] n_res;
    } sts_t;

endpackage

// File: sv/sawl_ctrl.sv
// Controller of the ARQ link engine: sequences accept, cache search and result emission.
// Depends on sawl_pkg for the command and status structs.
module sawl_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  sawl_pkg::sts_t sts,
    output sawl_pkg::cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EVAL   = 6'b000010,
        ST_SEARCH = 6'b000100,
        ST_DRAIN  = 6'b001000,
        ST_EMIT0  = 6'b010000,
        ST_EMIT1  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (sts.need_search) begin
                    cmd.search_clear = 1'b1;
                    state_next       = ST_SEARCH;
                end else begin
                    state_next = ST_EMIT0;
                end
            end
            ST_SEARCH: begin
                cmd.search_step = 1'b1;
                if (sts.search_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                cmd.search_drain = 1'b1;
                state_next       = ST_EMIT0;
            end
            ST_EMIT0: begin
                if (sts.n_res == 2'd0) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.load0 = 1'b1;
                    if (sts.n_res == 2'd1) begin
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_EMIT1;
                    end
                end
            end
            ST_EMIT1: begin
                if (sts.out_free) begin
                    cmd.load1  = 1'b1;
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/sawl_datapath.sv
// Datapath of the ARQ link engine: input latch, link state, seen-header ring,
// result planning and the output register. Depends on sawl_pkg.
module sawl_datapath #(
    parameter int ID_BITS     = sawl_pkg::DEF_ID_BITS,
    parameter int CACHE_DEPTH = sawl_pkg::DEF_CACHE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [sawl_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [sawl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [sawl_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [sawl_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sawl_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [sawl_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                                m_tlast,
    input  sawl_pkg::cmd_t                      cmd,
    output sawl_pkg::sts_t                      sts
);

    localparam int IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int HDR_W = 2 * sawl_pkg::CODE_W / 2 + 3 * sawl_pkg::ADDR_W + ID_BITS;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CACHE_DEPTH - 1);

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] dest;
        logic [7:0] src;
        logic [1:0] typ;
        logic [7:0] id;
        logic [7:0] flags;
        logic [1:0] status;
    } res_t;

    // Configuration registers.
    logic [7:0] own_addr_reg;
    logic [7:0] max_retries_reg;

    // Latched input item.
    logic [1:0] op_reg;
    logic [1:0] rxs_reg;
    logic [7:0] fdest_reg;
    logic [7:0] fsrc_reg;
    logic [1:0] ftype_reg;
    logic [7:0] fid_reg;
    logic [7:0] fflags_reg;
    logic [7:0] send_to_reg;
    logic       send_conf_reg;
    logic [7:0] send_flags_reg;

    // Link state.
    logic               waiting_reg;
    logic [7:0]         attempt_reg;
    logic [ID_BITS-1:0] next_id_reg;
    logic [7:0]         pend_dest_reg;
    logic [7:0]         pend_flags_reg;

    // Seen-header ring.
    logic [HDR_W-1:0]       seen_mem [CACHE_DEPTH];
    logic [CACHE_DEPTH-1:0] seen_valid_reg;
    logic [IDX_W-1:0]       head_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [HDR_W-1:0]       rd_hdr_reg;
    logic                   rd_ok_reg;
    logic                   cmp_pend_reg;
    logic                   found_reg;

    // Output register.
    logic       m_valid_reg;
    res_t       m_res_reg;
    logic       m_last_reg;

    // Planned results and state changes.
    res_t       r0, r1;
    logic [1:0] n_res;
    logic       do_finish, do_inc, do_start, do_store;
    logic [HDR_W-1:0] hdr_in;
    res_t       data_res, finish_res, ack_res, deliver_res, err_res;
    logic       rx_match, retries_used;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_addr_reg    <= '0;
            max_retries_reg <= sawl_pkg::MAX_RETRIES_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                sawl_pkg::CFG_OWN_ADDRESS: own_addr_reg    <= cfg_wdata;
                sawl_pkg::CFG_MAX_RETRIES: max_retries_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg         <= s_tuser;
            rxs_reg        <= s_tdata[1:0];
            fdest_reg      <= s_tdata[9:2];
            fsrc_reg       <= s_tdata[17:10];
            ftype_reg      <= s_tdata[19:18];
            fid_reg        <= s_tdata[27:20];
            fflags_reg     <= s_tdata[35:28];
            send_to_reg    <= s_tdata[43:36];
            send_conf_reg  <= s_tdata[44];
            send_flags_reg <= s_tdata[52:45];
        end
    end

    assign hdr_in = {ftype_reg, fdest_reg, fsrc_reg, fid_reg[ID_BITS-1:0], fflags_reg};

    always_comb begin
        rx_match     = (fdest_reg == own_addr_reg) && (ftype_reg == sawl_pkg::TYPE_ACK) &&
                       (fid_reg[ID_BITS-1:0] == next_id_reg);
        retries_used = (attempt_reg >= max_retries_reg);

        // A new send takes its destination and flags from the item itself.
        data_res.action = sawl_pkg::ACT_TRANSMIT;
        data_res.dest   = waiting_reg ? pend_dest_reg : send_to_reg;
        data_res.src    = own_addr_reg;
        data_res.typ    = (waiting_reg || send_conf_reg) ? sawl_pkg::TYPE_CONF
                                                         : sawl_pkg::TYPE_UNCONF;
        data_res.id     = 8'(next_id_reg);
        data_res.flags  = waiting_reg ? pend_flags_reg : send_flags_reg;
        data_res.status = sawl_pkg::ST_OK;

        finish_res        = data_res;
        finish_res.action = sawl_pkg::ACT_FINISH;

        ack_res.action = sawl_pkg::ACT_TRANSMIT;
        ack_res.dest   = fsrc_reg;
        ack_res.src    = own_addr_reg;
        ack_res.typ    = sawl_pkg::TYPE_ACK;
        ack_res.id     = 8'(fid_reg[ID_BITS-1:0]);
        ack_res.flags  = '0;
        ack_res.status = sawl_pkg::ST_OK;

        deliver_res.action = sawl_pkg::ACT_DELIVER;
        deliver_res.dest   = fdest_reg;
        deliver_res.src    = fsrc_reg;
        deliver_res.typ    = ftype_reg;
        deliver_res.id     = fid_reg;
        deliver_res.flags  = fflags_reg;
        deliver_res.status = sawl_pkg::ST_OK;

        err_res        = '0;
        err_res.action = sawl_pkg::ACT_FINISH;
        err_res.status = sawl_pkg::ST_RADIO;

        r0        = data_res;
        r1        = finish_res;
        n_res     = 2'd0;
        do_finish = 1'b0;
        do_inc    = 1'b0;
        do_start  = 1'b0;
        do_store  = 1'b0;

        if (waiting_reg) begin
            if (op_reg == sawl_pkg::OP_TIMEOUT) begin
                n_res = 2'd1;
                if (retries_used) begin
                    r0        = finish_res;
                    r0.status = sawl_pkg::ST_TIMEOUT;
                    do_finish = 1'b1;
                end else begin
                    do_inc = 1'b1;
                end
            end else if (op_reg == sawl_pkg::OP_RX) begin
                if (rxs_reg == sawl_pkg::RXS_CRC) begin
                    n_res  = 2'd1;
                    do_inc = 1'b1;
                end else if (rxs_reg == sawl_pkg::RXS_OK) begin
                    if (rx_match) begin
                        n_res     = 2'd1;
                        r0        = finish_res;
                        do_finish = 1'b1;
                    end
                end else begin
                    n_res     = 2'd1;
                    r0        = finish_res;
                    r0.status = sawl_pkg::ST_RADIO;
                    do_finish = 1'b1;
                end
            end
        end else if (op_reg == sawl_pkg::OP_SEND) begin
            do_start = 1'b1;
            n_res    = send_conf_reg ? 2'd1 : 2'd2;
        end else if (op_reg == sawl_pkg::OP_RX) begin
            if (rxs_reg == sawl_pkg::RXS_OK) begin
                if (fdest_reg == own_addr_reg) begin
                    if (ftype_reg == sawl_pkg::TYPE_CONF) begin
                        r0    = ack_res;
                        n_res = 2'd1;
                    end
                    if (!found_reg) begin
                        do_store = 1'b1;
                        if (n_res == 2'd0) begin
                            r0    = deliver_res;
                            n_res = 2'd1;
                        end else begin
                            r1    = deliver_res;
                            n_res = 2'd2;
                        end
                    end
                end
            end else if (rxs_reg != sawl_pkg::RXS_CRC) begin
                r0    = err_res;
                n_res = 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            waiting_reg    <= 1'b0;
            attempt_reg    <= '0;
            next_id_reg    <= '0;
            pend_dest_reg  <= '0;
            pend_flags_reg <= '0;
        end else if (cmd.commit) begin
            if (do_start) begin
                pend_dest_reg  <= send_to_reg;
                pend_flags_reg <= send_flags_reg;
                attempt_reg    <= 8'd1;
                if (send_conf_reg) begin
                    waiting_reg <= 1'b1;
                end else begin
                    next_id_reg <= next_id_reg + ID_BITS'(1);
                end
            end
            if (do_finish) begin
                waiting_reg <= 1'b0;
                next_id_reg <= next_id_reg + ID_BITS'(1);
            end
            if (do_inc && attempt_reg != sawl_pkg::ATTEMPT_MAX) begin
                attempt_reg <= attempt_reg + 8'd1;
            end
        end
    end

    // Ring write and search read port.
    always_ff @(posedge aclk) begin
        if (cmd.commit && do_store) begin
            seen_mem[head_reg] <= hdr_in;
        end
        if (cmd.search_step) begin
            rd_hdr_reg <= seen_mem[idx_reg];
        end
    end

    // The search issues one read per cycle and compares the previous read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_valid_reg <= '0;
            head_reg       <= '0;
            idx_reg        <= '0;
            rd_ok_reg      <= 1'b0;
            cmp_pend_reg   <= 1'b0;
            found_reg      <= 1'b0;
        end else begin
            if (cmd.commit && do_store) begin
                seen_valid_reg[head_reg] <= 1'b1;
                head_reg <= (head_reg == IDX_LAST) ? '0 : head_reg + IDX_W'(1);
            end
            if (cmd.search_clear) begin
                idx_reg      <= '0;
                cmp_pend_reg <= 1'b0;
                found_reg    <= 1'b0;
            end
            if (cmd.search_step || cmd.search_drain) begin
                if (cmp_pend_reg && rd_ok_reg && rd_hdr_reg == hdr_in) begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.search_step) begin
                rd_ok_reg    <= seen_valid_reg[idx_reg];
                cmp_pend_reg <= 1'b1;
                idx_reg      <= (idx_reg == IDX_LAST) ? '0 : idx_reg + IDX_W'(1);
            end
            if (cmd.search_drain) begin
                cmp_pend_reg <= 1'b0;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load0 || cmd.load1) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load0) begin
            m_res_reg  <= r0;
            m_last_reg <= (n_res == 2'd1);
        end else if (cmd.load1) begin
            m_res_reg  <= r1;
            m_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.action;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {4'b0, m_res_reg.status, m_res_reg.flags, m_res_reg.id,
                       m_res_reg.typ, m_res_reg.src, m_res_reg.dest};

    assign sts.need_search = !waiting_reg && op_reg == sawl_pkg::OP_RX &&
                             rxs_reg == sawl_pkg::RXS_OK && fdest_reg == own_addr_reg;
    assign sts.search_last = (idx_reg == IDX_LAST);
    assign sts.out_free    = !m_valid_reg || m_tready;
    assign sts.n_res       = n_res;

endmodule

// File: sv/stop_and_wait_arq_link_core.sv
// Flow: an item is accepted, evaluated and emitted (controller states IDLE, EVAL, EMIT0),
// with a second result from EMIT1. A received frame for this node is also checked against
// the seen-header ring, one entry per cycle, before it is emitted (SEARCH, then DRAIN).
// A new item is taken only once the controller is back in IDLE; the ring has a single
// read port. Results wait in an output register.
// Reset (aresetn, synchronous, active low) clears link state and ring valid bits and reloads config defaults.
module stop_and_wait_arq_link_core #(
    parameter int ID_BITS     = sawl_pkg::DEF_ID_BITS,
    parameter int CACHE_DEPTH = sawl_pkg::DEF_CACHE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [sawl_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [sawl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // rx_status, frame_dest, frame_src, frame_type, frame_id, frame_flags,
    // send_to, send_confirmed, send_flags, zero fill
    input  logic [sawl_pkg::S_TDATA_W-1:0]      s_tdata,
    // operation
    input  logic [sawl_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_dest, out_src, out_type, out_id, out_flags, status, zero fill
    output logic [sawl_pkg::M_TDATA_W-1:0]      m_tdata,
    // action
    output logic [sawl_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                                m_tlast
);

    sawl_pkg::cmd_t cmd;
    sawl_pkg::sts_t sts;

    sawl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sawl_datapath #(
        .ID_BITS     (ID_BITS),
        .CACHE_DEPTH (CACHE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// File: sv/sawl_checker.sv
// Port-level checks of the ARQ link engine, bound to the top level.
// Depends on sawl_pkg for result codes and field positions.
module sawl_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sawl_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [sawl_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                           m_tlast
);

    // No result is presented in the cycle after reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // The engine works on one item at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while busy");

    // Only a finish report carries a nonzero status, and no undefined action appears.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != sawl_pkg::ACT_BAD &&
                     (m_tuser == sawl_pkg::ACT_FINISH ||
                      m_tdata[sawl_pkg::M_STATUS_LSB +: 2] == sawl_pkg::ST_OK))
        else $error("bad action or status");

endmodule

bind stop_and_wait_arq_link_core sawl_checker u_sawl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: dv/stop_and_wait_arq_link_core_tb.sv
// Self-checking testbench for stop_and_wait_arq_link_core: random and directed link
// events go in on the s_ stream, and a scoreboard class predicts every m_ result item.
// Depends on sawl_pkg and the core RTL only.
module stop_and_wait_arq_link_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sawl_pkg::*;

    localparam int ID_BITS     = DEF_ID_BITS;
    localparam int CACHE_DEPTH = DEF_CACHE_DEPTH;
    localparam logic [ID_W-1:0] ID_MASK = ID_W'((1 << ID_BITS) - 1);
    localparam int SETTLE_CYCLES = 2 * (CACHE_DEPTH + 5) + 4;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_ITEMS   = 300;
    localparam int POOL_SIZE     = 12;

    // Codes that the package leaves unnamed.
    localparam logic [CODE_W-1:0] OP_NONE       = 2'd3;
    localparam logic [CODE_W-1:0] RXS_RADIO     = 2'd2;
    localparam logic [CODE_W-1:0] RXS_RADIO_ALT = 2'd3;
    localparam logic [CODE_W-1:0] TYPE_OTHER    = 2'd3;

    // Fields of one input item, packed as on s_tdata (last member in the lowest bits).
    typedef struct packed {
        logic [FLAGS_W-1:0] send_flags;
        logic               send_conf;
        logic [ADDR_W-1:0]  send_to;
        logic [FLAGS_W-1:0] flags;
        logic [ID_W-1:0]    id;
        logic [CODE_W-1:0]  kind;
        logic [ADDR_W-1:0]  src;
        logic [ADDR_W-1:0]  dest;
        logic [CODE_W-1:0]  rxs;
    } frame_item_t;

    typedef struct packed {
        logic [CODE_W-1:0]  action;
        logic [ADDR_W-1:0]  dest;
        logic [ADDR_W-1:0]  src;
        logic [CODE_W-1:0]  kind;
        logic [ID_W-1:0]    id;
        logic [FLAGS_W-1:0] flags;
        logic [CODE_W-1:0]  status;
        logic               last;
    } link_result_t;

    class arq_scoreboard;
        link_result_t       pending_q[$];
        int                 errors;
        logic [ADDR_W-1:0]  own_addr;
        logic [ATTEMPT_W-1:0] retry_limit;
        logic               awaiting_ack;
        logic [ATTEMPT_W-1:0] attempts;
        logic [ID_W-1:0]    next_id;
        logic [ADDR_W-1:0]  pend_dest;
        logic [FLAGS_W-1:0] pend_flags;
        logic [33:0]        ring_hdr[CACHE_DEPTH];
        logic               ring_valid[CACHE_DEPTH];
        int                 ring_wr;

        function new();
            errors = 0;
            own_addr = '0;
            retry_limit = MAX_RETRIES_RST;
            awaiting_ack = 1'b0;
            attempts = '0;
            next_id = '0;
            pend_dest = '0;
            pend_flags = '0;
            ring_wr = 0;
            for (int i = 0; i < CACHE_DEPTH; i++) begin
                ring_hdr[i] = '0;
                ring_valid[i] = 1'b0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_OWN_ADDRESS)
                own_addr = val;
            else if (idx == CFG_MAX_RETRIES)
                retry_limit = val;
        endfunction

        function void push(logic [CODE_W-1:0] action, logic [ADDR_W-1:0] dest,
                           logic [ADDR_W-1:0] src, logic [CODE_W-1:0] kind,
                           logic [ID_W-1:0] id, logic [FLAGS_W-1:0] flags,
                           logic [CODE_W-1:0] status);
            link_result_t r;
            r = '{action, dest, src, kind, id, flags, status, 1'b0};
            pending_q.push_back(r);
        endfunction

        function void emit_data(logic [CODE_W-1:0] kind);
            push(ACT_TRANSMIT, pend_dest, own_addr, kind, next_id, pend_flags, ST_OK);
            if (attempts != ATTEMPT_MAX)
                attempts++;
        endfunction

        function void emit_finish(logic [CODE_W-1:0] status, logic [CODE_W-1:0] kind);
            push(ACT_FINISH, pend_dest, own_addr, kind, next_id, pend_flags, status);
            awaiting_ack = 1'b0;
            next_id = (next_id + 1'b1) & ID_MASK;
        endfunction

        function void note_input(logic [CODE_W-1:0] op, frame_item_t it);
            int          n;
            logic [33:0] hdr;
            logic        known;
            n = 0;
            if (awaiting_ack) begin
                if (op == OP_TIMEOUT) begin
                    if (attempts >= retry_limit)
                        emit_finish(ST_TIMEOUT, TYPE_CONF);
                    else
                        emit_data(TYPE_CONF);
                    n = 1;
                end else if (op == OP_RX) begin
                    if (it.rxs == RXS_CRC) begin
                        emit_data(TYPE_CONF);
                        n = 1;
                    end else if (it.rxs == RXS_OK) begin
                        if (it.dest == own_addr && it.kind == TYPE_ACK &&
                            (it.id & ID_MASK) == next_id) begin
                            emit_finish(ST_OK, TYPE_CONF);
                            n = 1;
                        end
                    end else begin
                        emit_finish(ST_RADIO, TYPE_CONF);
                        n = 1;
                    end
                end
            end else if (op == OP_SEND) begin
                pend_dest = it.send_to;
                pend_flags = it.send_flags;
                attempts = '0;
                if (it.send_conf) begin
                    emit_data(TYPE_CONF);
                    awaiting_ack = 1'b1;
                    n = 1;
                end else begin
                    // An unconfirmed send reports type 0 on both the frame and the finish.
                    emit_data(TYPE_UNCONF);
                    emit_finish(ST_OK, TYPE_UNCONF);
                    n = 2;
                end
            end else if (op == OP_RX) begin
                if (it.rxs == RXS_OK) begin
                    if (it.dest == own_addr) begin
                        hdr = {it.kind, it.dest, it.src, it.id & ID_MASK, it.flags};
                        if (it.kind == TYPE_CONF) begin
                            push(ACT_TRANSMIT, it.src, own_addr, TYPE_ACK, it.id & ID_MASK,
                                 '0, ST_OK);
                            n++;
                        end
                        known = 1'b0;
                        for (int i = 0; i < CACHE_DEPTH; i++)
                            if (ring_valid[i] && ring_hdr[i] == hdr)
                                known = 1'b1;
                        if (!known) begin
                            push(ACT_DELIVER, it.dest, it.src, it.kind, it.id, it.flags, ST_OK);
                            n++;
                            ring_hdr[ring_wr] = hdr;
                            ring_valid[ring_wr] = 1'b1;
                            ring_wr = (ring_wr + 1) % CACHE_DEPTH;
                        end
                    end
                end else if (it.rxs != RXS_CRC) begin
                    push(ACT_FINISH, '0, '0, '0, '0, '0, ST_RADIO);
                    n++;
                end
            end
            if (n > 0)
                pending_q[pending_q.size() - 1].last = 1'b1;
        endfunction

        function void cmp(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(link_result_t got);
            link_result_t want;
            if (pending_q.size() == 0) begin
                $error("result item with nothing expected: action %0d", got.action);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            cmp("action", want.action, got.action);
            cmp("out_dest", want.dest, got.dest);
            cmp("out_src", want.src, got.src);
            cmp("out_type", want.kind, got.kind);
            cmp("out_id", want.id, got.id);
            cmp("out_flags", want.flags, got.flags);
            cmp("status", want.status, got.status);
            cmp("last_result", want.last, got.last);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  m_tlast;

    arq_scoreboard sb = new();
    bit  calm;
    bit  hold_req;
    int  cycle_count;
    logic [25:0] hdr_pool[POOL_SIZE];

    stop_and_wait_arq_link_core #(
        .ID_BITS     (ID_BITS),
        .CACHE_DEPTH (CACHE_DEPTH)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("stop_and_wait_arq_link_core_tb: FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        link_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.action = m_tuser;
            got.dest   = m_tdata[M_DEST_LSB +: ADDR_W];
            got.src    = m_tdata[M_SRC_LSB +: ADDR_W];
            got.kind   = m_tdata[M_TYPE_LSB +: CODE_W];
            got.id     = m_tdata[M_ID_LSB +: ID_W];
            got.flags  = m_tdata[M_FLAGS_LSB +: FLAGS_W];
            got.status = m_tdata[M_STATUS_LSB +: CODE_W];
            got.last   = m_tlast;
            sb.check_result(got);
        end
    end

    // Result side: random ready and stall stretches, plus one long hold-off on request.
    initial begin
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    function automatic frame_item_t rx_frame(logic [CODE_W-1:0] rxs, logic [ADDR_W-1:0] dest,
                                             logic [ADDR_W-1:0] src, logic [CODE_W-1:0] kind,
                                             logic [ID_W-1:0] id, logic [FLAGS_W-1:0] flags);
        frame_item_t it;
        it = '0;
        it.rxs = rxs;
        it.dest = dest;
        it.src = src;
        it.kind = kind;
        it.id = id;
        it.flags = flags;
        return it;
    endfunction

    function automatic frame_item_t send_req(logic [ADDR_W-1:0] to, logic conf,
                                             logic [FLAGS_W-1:0] flags);
        frame_item_t it;
        it = '0;
        it.send_to = to;
        it.send_conf = conf;
        it.send_flags = flags;
        return it;
    endfunction

    // The item is offered until taken; s_tvalid stays high unless a gap follows.
    task automatic push_item(logic [CODE_W-1:0] op, frame_item_t it);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {3'b000, it};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_input(op, it);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    // Frames that yield no result may still be in work, hence the settle time.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(logic [ADDR_W-1:0] own, logic [ATTEMPT_W-1:0] retries);
        while (sb.awaiting_ack)
            push_item(OP_RX, rx_frame(RXS_OK, sb.own_addr, 8'h00, TYPE_ACK, sb.next_id, 8'h00));
        drain();
        cfg_wr_en <= 1'b1;
        cfg_addr <= CFG_OWN_ADDRESS;
        cfg_wdata <= own;
        @(posedge aclk);
        sb.write_reg(CFG_OWN_ADDRESS, own);
        cfg_addr <= CFG_MAX_RETRIES;
        cfg_wdata <= retries;
        @(posedge aclk);
        sb.write_reg(CFG_MAX_RETRIES, retries);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly well-formed exchanges against the predicted link state, with some noise.
    task automatic random_item();
        logic [63:0]       r;
        logic [CODE_W-1:0] op;
        frame_item_t       it;
        int                pick;
        int                slot;
        r = {$urandom, $urandom};
        it = r[52:0];
        pick = $urandom_range(0, 99);
        if (sb.awaiting_ack) begin
            if (pick < 35) begin
                op = OP_RX;
                it.rxs = RXS_OK;
                it.dest = sb.own_addr;
                it.kind = TYPE_ACK;
                it.id = sb.next_id;
                // Near misses: the ACK differs in exactly one compared field.
                if (pick >= 25) begin
                    case ($urandom_range(0, 2))
                        0: it.dest[$urandom_range(0, ADDR_W - 1)] ^= 1'b1;
                        1: it.kind = ($urandom_range(0, 1) == 0) ? TYPE_CONF : TYPE_OTHER;
                        default: it.id[$urandom_range(0, ID_BITS - 1)] ^= 1'b1;
                    endcase
                end
            end else if (pick < 65) begin
                op = OP_TIMEOUT;
            end else if (pick < 80) begin
                op = OP_RX;
                it.rxs = RXS_CRC;
            end else if (pick < 85) begin
                op = OP_RX;
                it.rxs = ($urandom_range(0, 1) == 0) ? RXS_RADIO : RXS_RADIO_ALT;
            end else if (pick < 92) begin
                op = OP_SEND;
            end else begin
                op = ($urandom_range(0, 1) == 0) ? OP_NONE : OP_RX;
            end
        end else begin
            if (pick < 45) begin
                op = OP_SEND;
                it.send_conf = (pick < 30);
            end else if (pick < 78) begin
                op = OP_RX;
                it.rxs = RXS_OK;
                it.dest = sb.own_addr;
                slot = $urandom_range(0, POOL_SIZE - 1);
                if ($urandom_range(0, 2) != 0)
                    {it.src, it.kind, it.id, it.flags} = hdr_pool[slot];
                else
                    hdr_pool[slot] = {it.src, it.kind, it.id, it.flags};
            end else if (pick < 84) begin
                op = OP_RX;
                it.rxs = RXS_OK;
                it.dest = sb.own_addr ^ ADDR_W'($urandom_range(1, 255));
            end else if (pick < 90) begin
                op = OP_RX;
                it.rxs = ($urandom_range(0, 1) == 0) ? RXS_CRC : it.rxs;
            end else if (pick < 95) begin
                op = OP_TIMEOUT;
            end else begin
                op = OP_NONE;
            end
        end
        push_item(op, it);
    endtask

    logic [ADDR_W-1:0]    phase_own[5]   = '{8'h5A, 8'hFF, 8'h00, 8'hC3, 8'h81};
    logic [ATTEMPT_W-1:0] phase_retry[5] = '{8'd3, 8'd1, 8'd255, 8'd0, 8'd2};

    initial begin
        calm = 1'b0;
        hold_req = 1'b0;
        cycle_count = 0;
        for (int i = 0; i < POOL_SIZE; i++)
            hdr_pool[i] = 26'($urandom);
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, run with the reset values of both registers.
        push_item(OP_TIMEOUT, '0);
        push_item(OP_NONE, '1);
        push_item(OP_RX, rx_frame(RXS_CRC, 8'h00, 8'h01, TYPE_CONF, 8'h01, 8'h01));
        push_item(OP_RX, rx_frame(RXS_RADIO, 8'h00, 8'h01, TYPE_CONF, 8'h01, 8'h01));
        push_item(OP_RX, rx_frame(RXS_RADIO_ALT, 8'hFF, 8'hFF, TYPE_OTHER, 8'hFF, 8'hFF));
        push_item(OP_SEND, send_req(8'hFF, 1'b0, 8'hFF));
        push_item(OP_SEND, send_req(8'h00, 1'b1, 8'h00));
        push_item(OP_SEND, send_req(8'h12, 1'b1, 8'h34));
        push_item(OP_RX, rx_frame(RXS_OK, 8'h00, 8'h07, TYPE_ACK, sb.next_id + 1'b1, 8'h00));
        push_item(OP_RX, rx_frame(RXS_OK, 8'h00, 8'h07, TYPE_CONF, sb.next_id, 8'h00));
        push_item(OP_TIMEOUT, '0);
        push_item(OP_RX, rx_frame(RXS_CRC, 8'h00, 8'h07, TYPE_ACK, 8'h00, 8'h00));
        push_item(OP_TIMEOUT, '0);
        push_item(OP_SEND, send_req(8'h80, 1'b1, 8'hA5));
        push_item(OP_RX, rx_frame(RXS_OK, 8'h00, 8'h80, TYPE_ACK, sb.next_id, 8'h00));
        push_item(OP_SEND, send_req(8'h01, 1'b1, 8'h01));
        push_item(OP_RX, rx_frame(RXS_RADIO, 8'h00, 8'h01, TYPE_ACK, 8'h00, 8'h00));
        push_item(OP_RX, rx_frame(RXS_OK, 8'h00, 8'hFF, TYPE_CONF, 8'hFF, 8'hFF));
        push_item(OP_RX, rx_frame(RXS_OK, 8'h00, 8'hFF, TYPE_CONF, 8'hFF, 8'hFF));
        push_item(OP_RX, rx_frame(RXS_OK, 8'h00, 8'hFF, TYPE_OTHER, 8'hFF, 8'hFF));
        push_item(OP_RX, rx_frame(RXS_OK, 8'h01, 8'h02, TYPE_UNCONF, 8'h03, 8'h04));
        push_item(OP_RX, rx_frame(RXS_OK, 8'h00, 8'h02, TYPE_ACK, 8'h03, 8'h04));

        for (int p = 0; p < 5; p++) begin
            set_config(phase_own[p], phase_retry[p]);
            calm = (p == 4);
            if (phase_retry[p] == ATTEMPT_MAX) begin
                // Repeated CRC retransmits drive the attempt count into saturation.
                push_item(OP_SEND, send_req(8'h3C, 1'b1, 8'h96));
                repeat (258)
                    push_item(OP_RX, rx_frame(RXS_CRC, 8'h00, 8'h00, TYPE_ACK, 8'h00, 8'h00));
                push_item(OP_TIMEOUT, '0);
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 0 && k == 100)
                    hold_req = 1'b1;
                random_item();
            end
        end

        drain();
        if (sb.errors == 0)
            $display("stop_and_wait_arq_link_core_tb: PASS");
        else
            $display("stop_and_wait_arq_link_core_tb: FAIL");
        $finish;
    end

endmodule
